@@ rtl/core/cfpp_pkg.sv @@
// Shared types, constants and codes for the framed packet receiver.
`timescale 1ns / 1ps
package cfpp_pkg;

  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 10;
  localparam int ST_W    = 3;
  localparam int LEN_W   = 11;
  localparam int ADDR_W  = 32;
  localparam int HLEN_W  = 16;
  localparam int CRC_W   = 16;

  localparam int PACKET_MAX_DEF = 1024;
  localparam int STORE_DEPTH    = 1024;
  localparam int STORE_AW       = $clog2(STORE_DEPTH);

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hAA;
  localparam logic [CRC_W-1:0]  CRC_POLY   = 16'hA001;
  localparam logic [CRC_W-1:0]  CRC_INIT   = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE    = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_CONSUMED = 3'd0,
    ST_BUSY     = 3'd1,
    ST_GOOD     = 3'd2,
    ST_LEN_REJ  = 3'd3,
    ST_CRC_BAD  = 3'd4,
    ST_DONE     = 3'd5
  } result_code_t;

  typedef enum logic [3:0] {
    PH_H1   = 4'd0,
    PH_H2   = 4'd1,
    PH_LEN0 = 4'd2,
    PH_LEN1 = 4'd3,
    PH_AD0  = 4'd4,
    PH_AD1  = 4'd5,
    PH_AD2  = 4'd6,
    PH_AD3  = 4'd7,
    PH_DATA = 4'd8,
    PH_CRC0 = 4'd9,
    PH_CRC1 = 4'd10
  } phase_t;

  // store write port
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [BYTE_W-1:0]   data;
  } cfpp_wr_t;

  // per-beat result from the parser, values after the beat
  typedef struct packed {
    result_code_t        status;
    logic                frame_ready;
    logic [LEN_W-1:0]    frame_length;
    logic [ADDR_W-1:0]   frame_address;
  } cfpp_res_t;

endpackage

@@ rtl/core/cfpp_if.sv @@
// Valid/ready channel interfaces for the input and result beats.
`timescale 1ns / 1ps
interface cfpp_in_if;
  import cfpp_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] rx_byte;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, operation, rx_byte, read_index, input ready);
  modport sink   (input valid, operation, rx_byte, read_index, output ready);
endinterface

interface cfpp_out_if;
  import cfpp_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic              frame_ready;
  logic [LEN_W-1:0]  frame_length;
  logic [ADDR_W-1:0] frame_address;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, status, frame_ready, frame_length, frame_address, read_data,
                  input ready);
  modport sink   (input valid, status, frame_ready, frame_length, frame_address, read_data,
                  output ready);
endinterface

@@ rtl/core/cfpp_store.sv @@
// Data byte store: one write port, one registered read port.
`timescale 1ns / 1ps
module cfpp_store (
  input  logic                                clk,
  input  cfpp_pkg::cfpp_wr_t                  wr,
  input  logic                                rd_en,
  input  logic [cfpp_pkg::STORE_AW-1:0]       rd_addr,
  output logic [cfpp_pkg::BYTE_W-1:0]         rd_data
);
  import cfpp_pkg::*;

  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/cfpp_parser.sv @@
// Frame parser: header/length/address/data/CRC sequencer and latched frame state.
`timescale 1ns / 1ps
module cfpp_parser #(
  parameter int PACKET_MAX = cfpp_pkg::PACKET_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  cfpp_pkg::op_t              op,
  input  logic [cfpp_pkg::BYTE_W-1:0] rx_byte,
  output cfpp_pkg::cfpp_res_t        res,
  output logic [cfpp_pkg::HLEN_W-1:0] rd_limit,
  output cfpp_pkg::cfpp_wr_t         wr
);
  import cfpp_pkg::*;

  localparam int CNT_W = $clog2(PACKET_MAX + 1);
  localparam logic [HLEN_W:0] LEN_LIMIT = (HLEN_W + 1)'(PACKET_MAX);

  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] c_in,
                                                input logic [BYTE_W-1:0] v);
    logic [CRC_W-1:0] c;
    c = c_in ^ {{(CRC_W-BYTE_W){1'b0}}, v};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  phase_t              phase_r, phase_nxt;
  logic [HLEN_W-1:0]   len_r, len_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [CRC_W-1:0]    crc_r, crc_nxt;
  logic [BYTE_W-1:0]   crc_lo_r, crc_lo_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                rdy_r, rdy_nxt;
  logic [HLEN_W-1:0]   lat_len_r, lat_len_nxt;
  logic [ADDR_W-1:0]   lat_addr_r, lat_addr_nxt;

  result_code_t        status;
  logic [CRC_W-1:0]    crc_fed;
  logic [CNT_W-1:0]    cnt_inc;
  logic [HLEN_W-1:0]   len_full;
  logic                clear;

  assign crc_fed  = crc_feed(crc_r, rx_byte);
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign len_full = {rx_byte, len_r[BYTE_W-1:0]};

  always_comb begin
    phase_nxt    = phase_r;
    len_nxt      = len_r;
    addr_nxt     = addr_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    cnt_nxt      = cnt_r;
    rdy_nxt      = rdy_r;
    lat_len_nxt  = lat_len_r;
    lat_addr_nxt = lat_addr_r;
    status       = ST_DONE;
    clear        = 1'b0;
    wr.we        = 1'b0;
    wr.addr      = STORE_AW'(cnt_r);
    wr.data      = rx_byte;

    unique case (op)
      OP_BYTE: begin
        if (rdy_r) begin
          status = ST_BUSY;
        end else begin
          status = ST_CONSUMED;
          unique case (phase_r)
            PH_H1: begin
              if (rx_byte == HDR_FIRST) begin
                clear     = 1'b1;
                phase_nxt = PH_H2;
              end
            end
            PH_H2: begin
              phase_nxt = (rx_byte == HDR_SECOND) ? PH_LEN0 : PH_H1;
            end
            PH_LEN0: begin
              len_nxt   = HLEN_W'(rx_byte);
              crc_nxt   = crc_fed;
              phase_nxt = PH_LEN1;
            end
            PH_LEN1: begin
              len_nxt   = len_full;
              crc_nxt   = crc_fed;
              if ({1'b0, len_full} > LEN_LIMIT) begin
                clear     = 1'b1;
                phase_nxt = PH_H1;
                status    = ST_LEN_REJ;
              end else begin
                phase_nxt = PH_AD0;
              end
            end
            PH_AD0: begin
              addr_nxt  = ADDR_W'(rx_byte);
              crc_nxt   = crc_fed;
              phase_nxt = PH_AD1;
            end
            PH_AD1: begin
              addr_nxt[15:8] = rx_byte;
              crc_nxt        = crc_fed;
              phase_nxt      = PH_AD2;
            end
            PH_AD2: begin
              addr_nxt[23:16] = rx_byte;
              crc_nxt         = crc_fed;
              phase_nxt       = PH_AD3;
            end
            PH_AD3: begin
              addr_nxt[31:24] = rx_byte;
              crc_nxt         = crc_fed;
              // zero-length frame skips the data phase
              phase_nxt       = (len_r == '0) ? PH_CRC0 : PH_DATA;
            end
            PH_DATA: begin
              wr.we   = 1'b1;
              cnt_nxt = cnt_inc;
              crc_nxt = crc_fed;
              if ((HLEN_W + 1)'(cnt_inc) >= (HLEN_W + 1)'(len_r)) begin
                phase_nxt = PH_CRC0;
              end
            end
            PH_CRC0: begin
              crc_lo_nxt = rx_byte;
              phase_nxt  = PH_CRC1;
            end
            PH_CRC1: begin
              if ({rx_byte, crc_lo_r} == crc_r) begin
                lat_len_nxt  = len_r;
                lat_addr_nxt = addr_r;
                rdy_nxt      = 1'b1;
                status       = ST_GOOD;
              end else begin
                status = ST_CRC_BAD;
              end
              clear     = 1'b1;
              phase_nxt = PH_H1;
            end
            default: begin
              clear     = 1'b1;
              phase_nxt = PH_H1;
            end
          endcase
        end
      end
      OP_RELEASE: rdy_nxt = 1'b0;
      OP_READ:    status = ST_DONE;
      default:    status = ST_DONE;
    endcase

    if (clear) begin
      len_nxt    = '0;
      addr_nxt   = '0;
      crc_nxt    = CRC_INIT;
      crc_lo_nxt = '0;
      cnt_nxt    = '0;
    end

    wr.we = wr.we && step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_H1;
      len_r      <= '0;
      addr_r     <= '0;
      crc_r      <= CRC_INIT;
      crc_lo_r   <= '0;
      cnt_r      <= '0;
      rdy_r      <= 1'b0;
      lat_len_r  <= '0;
      lat_addr_r <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      len_r      <= len_nxt;
      addr_r     <= addr_nxt;
      crc_r      <= crc_nxt;
      crc_lo_r   <= crc_lo_nxt;
      cnt_r      <= cnt_nxt;
      rdy_r      <= rdy_nxt;
      lat_len_r  <= lat_len_nxt;
      lat_addr_r <= lat_addr_nxt;
    end
  end

  // reported length is the low field bits; reads are bounded by the full length
  assign res.status        = status;
  assign res.frame_ready   = rdy_nxt;
  assign res.frame_length  = lat_len_nxt[LEN_W-1:0];
  assign res.frame_address = lat_addr_nxt;
  assign rd_limit          = lat_len_nxt;

endmodule

@@ rtl/core/crc16_framed_packet_parser_unit.sv @@
// Top level of the CRC16 framed packet receiver.
//
// Input channel in_ch: one beat per operation (byte received, read stored
// data byte, release latched frame). Result channel out_ch: exactly one
// result beat per input beat, in order.
// Pipeline: input register, parse stage (parser state update, store write
// or store read), result register. out_ch.valid rises once the beat's result
// is in the result register; one beat per cycle is sustained when the
// receiver keeps out_ch.ready high. Data bytes land in a 1024-byte store
// with one write and one registered read port; the read for a beat is
// issued in its parse stage, after all earlier writes.
// Reset (rst_n low, synchronous) clears the parser to wait for the first
// header byte, drops the frame-ready flag and zeroes the latched length
// and address. The data store is not cleared; a read at or past the
// latched length returns zero.
// When out_ch.ready is low the result is held; each stage that is empty
// still takes a beat, so in_ch.ready drops only once all three stages are
// full.
`timescale 1ns / 1ps
module crc16_framed_packet_parser_unit #(
  parameter int PACKET_MAX = cfpp_pkg::PACKET_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  cfpp_in_if.sink           in_ch,
  cfpp_out_if.source        out_ch
);
  import cfpp_pkg::*;

  // stage 1: input register
  logic                 v1_r;
  op_t                  op1_r;
  logic [BYTE_W-1:0]    byte1_r;
  logic [IDX_W-1:0]     idx1_r;

  // stage 2: parse result
  logic                 v2_r;
  cfpp_res_t            res2_r;
  logic                 rd_ok2_r;

  // stage 3: output register
  logic                 ov_r;
  cfpp_res_t            res3_r;
  logic [BYTE_W-1:0]    rd3_r;

  logic                 en1, en2, en3;
  logic                 proc;
  cfpp_res_t            res;
  logic [HLEN_W-1:0]    rd_limit;
  cfpp_wr_t             wr;
  logic [BYTE_W-1:0]    rd_data;
  logic                 rd_en;
  logic                 rd_ok;

  assign en3  = !ov_r || out_ch.ready;
  assign en2  = !v2_r || en3;
  assign en1  = !v1_r || en2;
  assign proc = v1_r && en2;

  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_ch.valid) begin
      op1_r   <= op_t'(in_ch.operation);
      byte1_r <= in_ch.rx_byte;
      idx1_r  <= in_ch.read_index;
    end
  end

  cfpp_parser #(
    .PACKET_MAX (PACKET_MAX)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (proc),
    .op       (op1_r),
    .rx_byte  (byte1_r),
    .res      (res),
    .rd_limit (rd_limit),
    .wr       (wr)
  );

  assign rd_en = proc && (op1_r == OP_READ);
  // a read leaves the latched length untouched, so the parser's length bounds it
  assign rd_ok = (op1_r == OP_READ) &&
                 ({{(HLEN_W-IDX_W){1'b0}}, idx1_r} < rd_limit);

  cfpp_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (STORE_AW'(idx1_r)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res2_r   <= res;
      rd_ok2_r <= rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en3) begin
      ov_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      res3_r <= res2_r;
      rd3_r  <= rd_ok2_r ? rd_data : '0;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.status        = res3_r.status;
  assign out_ch.frame_ready   = res3_r.frame_ready;
  assign out_ch.frame_length  = res3_r.frame_length;
  assign out_ch.frame_address = res3_r.frame_address;
  assign out_ch.read_data     = rd3_r;

  // a busy answer only comes while a frame is latched
  a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && res3_r.status == ST_BUSY) |-> res3_r.frame_ready)
    else $error("busy status without latched frame");

  a_good_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && res3_r.status == ST_GOOD) |-> res3_r.frame_ready)
    else $error("good frame did not set frame_ready");

  a_rd_status: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && rd3_r != '0) |-> (res3_r.status == ST_DONE))
    else $error("read data on a non-read result");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && ov_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while pipeline full and stalled");

endmodule

@@ sim/tb_crc16_framed_packet_parser_unit.sv @@
// Testbench for the CRC16 framed packet receiver: directed and random frames, scoreboard check.
`timescale 1ns / 1ps
module tb_crc16_framed_packet_parser_unit;
  import cfpp_pkg::*;

  typedef struct {
    result_code_t      status;
    logic              frame_ready;
    logic [LEN_W-1:0]  frame_length;
    logic [ADDR_W-1:0] frame_address;
    logic [BYTE_W-1:0] read_data;
  } reply_t;

  // Tracks the receiver state beat by beat and holds the replies still owed.
  class parser_scoreboard;
    phase_t            phase;
    logic [HLEN_W-1:0] len_acc;
    logic [ADDR_W-1:0] addr_acc;
    logic [CRC_W-1:0]  crc;
    logic [BYTE_W-1:0] crc_lo;
    int                data_count;
    logic [BYTE_W-1:0] store [STORE_DEPTH];
    int                written_top;
    bit                frame_held;
    logic [HLEN_W-1:0] held_len;
    logic [ADDR_W-1:0] held_addr;
    reply_t            pending_replies[$];
    int                errors;
    int                fed_beats;

    function new();
      restart_parse();
      written_top = 0;
      frame_held  = 1'b0;
      held_len    = '0;
      held_addr   = '0;
      errors      = 0;
      fed_beats   = 0;
    endfunction

    static function logic [CRC_W-1:0] crc16_step(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] v);
      logic [CRC_W-1:0] r;
      r = c ^ {8'h00, v};
      for (int k = 0; k < 8; k++) begin
        r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
    endfunction

    function void restart_parse();
      phase      = PH_H1;
      len_acc    = '0;
      addr_acc   = '0;
      crc        = CRC_INIT;
      crc_lo     = '0;
      data_count = 0;
    endfunction

    function result_code_t parse_byte(logic [BYTE_W-1:0] v);
      result_code_t st;
      st = ST_CONSUMED;
      // length, address and data bytes all go through the CRC
      if (phase >= PH_LEN0 && phase <= PH_DATA) crc = crc16_step(crc, v);
      case (phase)
        PH_H1: if (v == HDR_FIRST) begin
          restart_parse();
          phase = PH_H2;
        end
        PH_H2:   phase = (v == HDR_SECOND) ? PH_LEN0 : PH_H1;
        PH_LEN0: begin
          len_acc = {8'h00, v};
          phase   = PH_LEN1;
        end
        PH_LEN1: begin
          len_acc[15:8] = v;
          if (len_acc > PACKET_MAX_DEF) begin
            restart_parse();
            st = ST_LEN_REJ;
          end else begin
            phase = PH_AD0;
          end
        end
        PH_AD0: begin
          addr_acc = {24'h0, v};
          phase    = PH_AD1;
        end
        PH_AD1: begin
          addr_acc[15:8] = v;
          phase          = PH_AD2;
        end
        PH_AD2: begin
          addr_acc[23:16] = v;
          phase           = PH_AD3;
        end
        PH_AD3: begin
          addr_acc[31:24] = v;
          phase           = (len_acc == 0) ? PH_CRC0 : PH_DATA;
        end
        PH_DATA: begin
          store[data_count % STORE_DEPTH] = v;
          data_count++;
          if (data_count > written_top) written_top = data_count;
          if (data_count >= len_acc) phase = PH_CRC0;
        end
        PH_CRC0: begin
          crc_lo = v;
          phase  = PH_CRC1;
        end
        PH_CRC1: begin
          if ({v, crc_lo} == crc) begin
            held_len   = len_acc;
            held_addr  = addr_acc;
            frame_held = 1'b1;
            st         = ST_GOOD;
          end else begin
            st = ST_CRC_BAD;
          end
          restart_parse();
        end
        default: restart_parse();
      endcase
      return st;
    endfunction

    function void note_input(op_t op, logic [BYTE_W-1:0] v, logic [IDX_W-1:0] idx);
      reply_t r;
      r.status    = ST_DONE;
      r.read_data = '0;
      case (op)
        OP_BYTE:    r.status = frame_held ? ST_BUSY : parse_byte(v);
        OP_READ:    if (idx < held_len) r.read_data = store[idx];
        OP_RELEASE: frame_held = 1'b0;
        default: ;
      endcase
      r.frame_ready   = frame_held;
      r.frame_length  = held_len[LEN_W-1:0];
      r.frame_address = held_addr;
      pending_replies.push_back(r);
      fed_beats++;
    endfunction

    function void check_result(logic [ST_W-1:0] s, logic fr, logic [LEN_W-1:0] len,
                               logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] rd);
      reply_t e;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: status %0d", s);
        return;
      end
      e = pending_replies.pop_front();
      if (e.status !== s || e.frame_ready !== fr || e.frame_length !== len ||
          e.frame_address !== addr || e.read_data !== rd) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp: st=%0d rdy=%0b len=%0d addr=%08h data=%02h",
                   e.status, e.frame_ready, e.frame_length, e.frame_address, e.read_data);
          $display("         got: st=%0d rdy=%0b len=%0d addr=%08h data=%02h",
                   s, fr, len, addr, rd);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   tx_idle = 1'b1;
  bit   rx_idle = 1'b1;
  int   results_taken = 0;

  parser_scoreboard sb = new();

  cfpp_in_if  in_ch();
  cfpp_out_if out_ch();

  crc16_framed_packet_parser_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic send_beat(op_t op, logic [BYTE_W-1:0] v, logic [IDX_W-1:0] idx);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_idle = !tx_idle;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.rx_byte    <= v;
    in_ch.read_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(op, v, idx);
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] v);
    send_beat(OP_BYTE, v, IDX_W'($urandom));
  endtask

  task automatic send_read(logic [IDX_W-1:0] idx);
    send_beat(OP_READ, BYTE_W'($urandom), idx);
  endtask

  task automatic send_release();
    send_beat(OP_RELEASE, BYTE_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic send_no_op();
    send_beat(OP_NONE, BYTE_W'($urandom), IDX_W'($urandom));
  endtask

  // only indices already written are read back; when a length is held, about half fall inside it
  task automatic send_random_read();
    int idx;
    if (sb.written_top == 0) begin
      send_no_op();
    end else begin
      if (sb.held_len != 0 && $urandom_range(0, 1) == 1)
        idx = $urandom_range(0, int'(sb.held_len) - 1);
      else
        idx = $urandom_range(0, sb.written_top - 1);
      send_read(IDX_W'(idx));
    end
  endtask

  // an oversize length stops after the length field, since the parser drops it there
  task automatic send_frame(logic [HLEN_W-1:0] len, logic [ADDR_W-1:0] addr, bit bad_crc);
    logic [BYTE_W-1:0] body[$];
    logic [CRC_W-1:0]  c;
    body = '{len[7:0], len[15:8], addr[7:0], addr[15:8], addr[23:16], addr[31:24]};
    for (int i = 0; i < int'(len) && len <= PACKET_MAX_DEF; i++) body.push_back(BYTE_W'($urandom));
    c = CRC_INIT;
    foreach (body[i]) c = parser_scoreboard::crc16_step(c, body[i]);
    if (bad_crc) c ^= CRC_W'($urandom_range(1, 65535));
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    if (len > PACKET_MAX_DEF) begin
      send_byte(len[7:0]);
      send_byte(len[15:8]);
    end else begin
      foreach (body[i]) send_byte(body[i]);
      send_byte(c[7:0]);
      send_byte(c[15:8]);
    end
  endtask

  initial begin : stimulus
    int               pick;
    logic [HLEN_W-1:0] len;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_NONE;
    in_ch.rx_byte    <= '0;
    in_ch.read_index <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_no_op();
    send_release();
    // second header byte wrong and itself a first header byte
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_frame(16'd1025, '0, 1'b0);
    send_frame(16'd0, 32'hFFFF_FFFF, 1'b0);
    send_byte(8'hFF);
    send_release();
    send_frame(16'hFFFF, '0, 1'b0);

    // one long frame, then reads at and just past its end
    send_frame(16'd256, 32'($urandom), 1'b0);
    send_read(10'd255);
    send_read(10'd0);
    send_read(10'd256);
    send_byte(8'h00);
    send_release();
    send_read(10'd255);

    while (sb.fed_beats < 900) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = ($urandom_range(0, 9) == 0) ? HLEN_W'($urandom_range(0, 80))
                                          : HLEN_W'($urandom_range(0, 12));
        send_frame(len, 32'($urandom), 1'b0);
      end else if (pick < 65) begin
        send_frame(HLEN_W'($urandom_range(0, 12)), 32'($urandom), 1'b1);
      end else if (pick < 72) begin
        send_frame(HLEN_W'($urandom_range(PACKET_MAX_DEF + 1, 65535)), 32'($urandom), 1'b0);
      end else if (pick < 80) begin
        // frame cut short; whatever follows is parsed as its tail
        len = HLEN_W'($urandom_range(0, 12));
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(len[7:0]);
        send_byte(8'h00);
        repeat ($urandom_range(0, int'(len) + 5)) send_byte(BYTE_W'($urandom));
      end else if (pick < 85) begin
        send_byte(HDR_FIRST);
        send_byte(BYTE_W'($urandom));
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
      end else begin
        case ($urandom_range(0, 2))
          0:       send_random_read();
          1:       send_release();
          default: send_no_op();
        endcase
      end
      if (sb.frame_held || $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(0, 2)) send_byte(BYTE_W'($urandom));
        repeat ($urandom_range(0, 4)) send_random_read();
        if ($urandom_range(0, 9) != 0) send_release();
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_replies.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin : result_sink
    int gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
      gap = rx_idle ? $urandom_range(0, 14) : 0;
      // long hold-off: the pipeline fills and back-pressures the input
      if (results_taken == 400 || results_taken == 800) gap = 150;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.status, out_ch.frame_ready, out_ch.frame_length,
                      out_ch.frame_address, out_ch.read_data);
      results_taken++;
    end
  end

  initial begin : watchdog
    #(5_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
